// ===== rtl/ntss_pkg.sv =====
package ntss_pkg;

  localparam int IDX_MAX_W = 16;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_MATCH  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  localparam logic CMD_LOAD = 1'b0;

  typedef struct packed {
    logic       cmd;
    logic [7:0] sig_top_left;
    logic [7:0] sig_top_right;
    logic [7:0] sig_bottom_left;
    logic [7:0] sig_bottom_right;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] best_index;
    logic [17:0] best_distance;
  } out_req_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [IDX_MAX_W-1:0] idx;
  } scan_tag_t;

endpackage

// ===== rtl/ntss_dist.sv =====
module ntss_dist
  import ntss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  scan_tag_t   tag_in,
  input  logic [31:0] entry,
  input  logic [31:0] query,
  output scan_tag_t   tag_out,
  output logic [17:0] ssd
);

  logic [15:0] sq_nxt [4];
  logic [15:0] sq_r   [4];
  scan_tag_t   tag1_r;
  scan_tag_t   tag2_r;
  logic [17:0] sum_r;

  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    for (int k = 0; k < 4; k++) begin
      a = entry[8*k +: 8];
      b = query[8*k +: 8];
      d = (a >= b) ? (a - b) : (b - a);
      sq_nxt[k] = 16'(d) * 16'(d);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sq_r[k] <= sq_nxt[k];
    end
    sum_r <= 18'(sq_r[0]) + 18'(sq_r[1]) + 18'(sq_r[2]) + 18'(sq_r[3]);
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  assign tag_out = tag2_r;
  assign ssd     = sum_r;

endmodule

// ===== rtl/nearest_tile_signature_search.sv =====
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-----------------------------------------
// in       | in  | in_valid/in_stall  | in_data  (cmd, four signature bytes)
// out      | out | out_valid/out_stall| out_data (status, best_index, best_distance)
//
// A load or a query on an empty table is answered in the idle state, without a scan.
// A query makes one read of the signature memory per cycle on its single read
// port, then goes through three stages of distance and compare.
// Reset clears the entry count and control state; the memory is not cleared.
// A result waits in the output register under out_stall while the next request
// is accepted; a second result waiting behind it holds off in_ valid requests.
module nearest_tile_signature_search
  import ntss_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_HOLD} state_t;

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_data_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] entry_cnt_r, entry_cnt_nxt;
  logic [IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [31:0]      qry_r, qry_nxt;
  logic [17:0]      best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  out_req_t         res_r, res_nxt;
  out_req_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  scan_tag_t        rd_tag_r, rd_tag_nxt;

  scan_tag_t        dist_tag;
  logic [17:0]      ssd;
  logic             acc;
  logic             full;
  logic             mem_we;
  logic             out_free;
  logic [31:0]      in_sig;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] last_idx;
  logic             take;
  logic             res_fire;
  out_req_t         res_now;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign full     = (entry_cnt_r == CNT_W'(TABLE_DEPTH));
  assign mem_we   = acc && (in_data.cmd == CMD_LOAD) && !full;
  assign out_free = !out_valid_r || !out_stall;
  assign in_sig   = {in_data.sig_bottom_right, in_data.sig_bottom_left,
                     in_data.sig_top_right, in_data.sig_top_left};
  assign cnt_m1   = entry_cnt_r - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign take     = (ssd <= best_dist_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[entry_cnt_r[IDX_W-1:0]] <= in_sig;
    end
    rd_data_r <= mem[scan_addr_r];
  end

  ntss_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (rd_tag_r),
    .entry   (rd_data_r),
    .query   (qry_r),
    .tag_out (dist_tag),
    .ssd     (ssd)
  );

  always_comb begin
    state_nxt     = state_r;
    entry_cnt_nxt = entry_cnt_r;
    scan_addr_nxt = scan_addr_r;
    qry_nxt       = qry_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_tag_nxt    = '0;
    res_fire      = 1'b0;
    res_now       = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.cmd == CMD_LOAD) begin
            res_fire = 1'b1;
            if (full) begin
              res_now.status = ST_FULL;
            end else begin
              res_now.status = ST_LOADED;
              entry_cnt_nxt  = entry_cnt_r + CNT_W'(1);
            end
          end else if (entry_cnt_r == '0) begin
            res_fire       = 1'b1;
            res_now.status = ST_EMPTY;
          end else begin
            qry_nxt       = in_sig;
            scan_addr_nxt = '0;
            best_dist_nxt = '1;
            best_idx_nxt  = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_tag_nxt.valid = 1'b1;
        rd_tag_nxt.last  = (scan_addr_r == last_idx);
        rd_tag_nxt.idx   = IDX_MAX_W'(scan_addr_r);
        if (scan_addr_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (dist_tag.valid) begin
      if (take) begin
        best_dist_nxt = ssd;
        best_idx_nxt  = IDX_W'(dist_tag.idx);
      end
      if (dist_tag.last) begin
        res_fire              = 1'b1;
        res_now.status        = ST_MATCH;
        res_now.best_index    = take ? 12'(dist_tag.idx) : 12'(best_idx_r);
        res_now.best_distance = take ? ssd : best_dist_r;
      end
    end

    if (res_fire) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res_now;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = res_now;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    qry_r       <= qry_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entry_cnt_r <= '0;
      out_valid_r <= 1'b0;
      rd_tag_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_tag_r    <= rd_tag_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_LOAD && !full)
      |=> (entry_cnt_r == $past(entry_cnt_r) + CNT_W'(1)))
    else $error("accepted load did not advance entry count");

  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dist_tag.valid |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("distance result outside a scan");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_tag.valid && dist_tag.last) |=> (state_r == S_IDLE || state_r == S_HOLD))
    else $error("scan did not finish after last entry");

endmodule

// ===== tb/nearest_tile_signature_checker.sv =====
`timescale 1ns / 100ps
module nearest_tile_signature_checker
  import ntss_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_req_t out_data,
  output int       mismatch_count,
  output int       results_owed
);

  logic [31:0] signature_table [TABLE_DEPTH];
  int          entries_held = 0;
  out_req_t    expected_results_q [$];
  out_req_t    want;
  out_req_t    predicted;
  int          fail_total = 0;
  int          owed = 0;

  assign mismatch_count = fail_total;
  assign results_owed   = owed;

  function automatic out_req_t nearest_entry_result(input in_req_t req);
    out_req_t    res;
    logic [31:0] probe;
    logic [31:0] entry;
    int unsigned a;
    int unsigned b;
    int unsigned diff;
    int unsigned sq_sum;
    int unsigned best_dist;
    int unsigned best_idx;
    res = '0;
    probe = {req.sig_bottom_right, req.sig_bottom_left, req.sig_top_right, req.sig_top_left};
    if (req.cmd == CMD_LOAD) begin
      if (entries_held < TABLE_DEPTH) begin
        signature_table[entries_held] = probe;
        entries_held++;
        res.status = ST_LOADED;
      end else begin
        res.status = ST_FULL;
      end
    end else if (entries_held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best_dist = 32'hFFFF_FFFF;
      best_idx = 0;
      for (int i = 0; i < entries_held; i++) begin
        entry = signature_table[i];
        sq_sum = 0;
        for (int k = 0; k < 4; k++) begin
          a = entry[8*k +: 8];
          b = probe[8*k +: 8];
          diff = (a >= b) ? a - b : b - a;
          sq_sum += diff * diff;
        end
        // later entry wins a tie
        if (sq_sum <= best_dist) begin
          best_dist = sq_sum;
          best_idx = i;
        end
      end
      res.status = ST_MATCH;
      res.best_index = best_idx[11:0];
      res.best_distance = best_dist[17:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d index %0d distance %0d",
                   $time, out_data.status, out_data.best_index, out_data.best_distance);
          fail_total++;
        end else begin
          want = expected_results_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_data.status);
            fail_total++;
          end
          if (out_data.best_index !== want.best_index) begin
            $display("%0t: best_index mismatch: expected %0d, got %0d",
                     $time, want.best_index, out_data.best_index);
            fail_total++;
          end
          if (out_data.best_distance !== want.best_distance) begin
            $display("%0t: best_distance mismatch: expected %0d, got %0d",
                     $time, want.best_distance, out_data.best_distance);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted = nearest_entry_result(in_data);
        expected_results_q = {expected_results_q, predicted};
      end
      owed = expected_results_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import ntss_pkg::*;

  localparam int   TABLE_DEPTH    = 4096;
  localparam int   WATCHDOG_LIMIT = 25000;
  localparam logic CMD_QUERY      = ~CMD_LOAD;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  logic     gaps_on = 1'b0;
  int       mismatch_count;
  int       results_owed;
  int       quiet_cycles = 0;
  in_req_t  loaded_sigs [$];

  nearest_tile_signature_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  nearest_tile_signature_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [7:0] tl, input logic [7:0] tr,
                              input logic [7:0] bl, input logic [7:0] br);
    in_req_t req;
    req = '{cmd, tl, tr, bl, br};
    if (cmd == CMD_LOAD && loaded_sigs.size() < TABLE_DEPTH) begin
      loaded_sigs = {loaded_sigs, req};
    end
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic random_request();
    logic    cmd;
    in_req_t src;
    cmd = ($urandom_range(99) < 45) ? CMD_LOAD : CMD_QUERY;
    src = '{cmd, pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    // reuse a stored signature, exact or a near miss, to force ties and zero distances
    if (loaded_sigs.size() != 0 && $urandom_range(2) == 0) begin
      src = loaded_sigs[$urandom_range(loaded_sigs.size() - 1)];
      src.sig_bottom_left = src.sig_bottom_left + 8'($urandom_range(2));
    end
    send_request(cmd, src.sig_top_left, src.sig_top_right, src.sig_bottom_left,
                 src.sig_bottom_right);
  endtask

  initial begin
    in_req_t last_sig;
    in_req_t first_sig;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_request(CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(CMD_LOAD,  8'h00, 8'h00, 8'h00, 8'h00);
    send_request(CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(CMD_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(CMD_LOAD,  8'h00, 8'h00, 8'h00, 8'h00);
    send_request(CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(CMD_LOAD,  8'h80, 8'h80, 8'h80, 8'h80);
    send_request(CMD_QUERY, 8'h40, 8'h40, 8'h40, 8'h40);
    send_request(CMD_LOAD,  8'hFF, 8'h00, 8'hFF, 8'h00);
    send_request(CMD_LOAD,  8'h00, 8'hFF, 8'h00, 8'hFF);
    send_request(CMD_QUERY, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_request(CMD_QUERY, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_request(CMD_LOAD,  8'h01, 8'h02, 8'h03, 8'h04);
    send_request(CMD_QUERY, 8'h04, 8'h03, 8'h02, 8'h01);
    send_request(CMD_QUERY, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
    wait_for_results();

    for (int n = 0; n < 110; n++) begin
      gaps_on = !(n >= 30 && n < 80);
      if (n == 60) wait_for_results();
      random_request();
    end
    wait_for_results();

    last_sig = loaded_sigs[loaded_sigs.size() - 1];
    first_sig = loaded_sigs[0];
    send_request(CMD_QUERY, last_sig.sig_top_left, last_sig.sig_top_right,
                 last_sig.sig_bottom_left, last_sig.sig_bottom_right);
    send_request(CMD_QUERY, first_sig.sig_top_left, first_sig.sig_top_right,
                 first_sig.sig_bottom_left, first_sig.sig_bottom_right);
    send_request(CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) begin
      send_request(CMD_QUERY, pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end
    send_request(CMD_LOAD, 8'h5A, 8'hA5, 8'h5A, 8'hA5);

    wait_for_results();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== nearest_tile_signature_search.f =====
rtl/ntss_pkg.sv
rtl/ntss_dist.sv
rtl/nearest_tile_signature_search.sv
tb/nearest_tile_signature_checker.sv
tb/testbench.sv
